// ===== rtl/dose_reference_normalizer_defines.svh =====
// Assertion helpers shared by the RTL of the dose reference normalizer.
`ifndef DOSE_REFERENCE_NORMALIZER_DEFINES_SVH
`define DOSE_REFERENCE_NORMALIZER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DRN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DRN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/drn_pkg.sv =====
`timescale 1ns / 1ps

package drn_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int DOSE_W          = 32;
    localparam int IN_IDX_W        = 10;
    localparam int CFG_IDX_W       = 2;
    localparam int STATUS_W        = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_METRIC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIMUL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRUCT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESC  = 2'd3;

    localparam logic [1:0] METRIC_MAX  = 2'd0;
    localparam logic [1:0] METRIC_MEAN = 2'd1;
    localparam logic [1:0] METRIC_D90  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ZERO_REF = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_READ     = 1'b1;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_DOSE   = 1'b1;

    localparam logic [3:0] TENTH_WRAP = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIN,
        ST_SHIFT,
        ST_DIV_MEAN,
        ST_REF,
        ST_DIV_SCALE,
        ST_REPORT,
        ST_RD_MUL,
        ST_RD_OUT
    } t_state;

    typedef struct packed {
        logic              clr;
        logic              ins;
        logic              shift;
        logic [DOSE_W-1:0] v;
    } t_chain_ctl;

endpackage

// ===== rtl/dose_reference_normalizer.sv =====
`timescale 1ns / 1ps
// Dose reference normalizer. Load beats (op 0) store a dose sample while the store
// has room and, if it is selected, insert it into a sorted chain of cells while
// max, sum and count are tracked; a load that does not close the set leaves busy
// low, so start may be high again in the next cycle. The load that carries
// last_sample closes the set and busy stays high until the finalize report: a
// decision step, then for the mean a quotient pass or for D90 chain shifts until
// rank count/10 is at the chain head, a reference check and a scale division,
// then the report (DIVW = max(32+FRAC_BITS, 32+clog2(MAX_SAMPLES+1)) bits, 48 at
// defaults). A finalize that needs no reference (not simultaneous, or nothing
// selected) goes from the decision straight to the report, and a zero reference
// skips the scale division. Both divisions run on one shared bit-per-cycle
// divider. A read beat (op 1) registers a sample memory word, multiplies it by the
// scale in ST_RD_MUL and shows the result in ST_RD_OUT; busy stays high through
// both states. Every result is on the o_ ports for one cycle with o_strobe high,
// and the receiver cannot stall it. Configuration is to be written only while busy
// is low; the block itself does not enforce it.
`include "dose_reference_normalizer_defines.svh"

module dose_reference_normalizer import drn_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_op,
    input  logic [DOSE_W-1:0]    i_dose_value,
    input  logic                 i_in_structure,
    input  logic                 i_last_sample,
    input  logic [IN_IDX_W-1:0]  i_read_index,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DOSE_W-1:0]    i_cfg_data,
    output logic                 o_strobe,
    output logic                 o_kind,
    output logic [DOSE_W-1:0]    o_value,
    output logic [STATUS_W-1:0]  o_status
);

    localparam int IDXW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNTW  = $clog2(MAX_SAMPLES + 1);
    localparam int SUMW  = DOSE_W + CNTW;
    localparam int SCLW  = DOSE_W + FRAC_BITS;
    localparam int DIVW  = (SUMW > SCLW) ? SUMW : SCLW;
    localparam int CMPW  = (CNTW > IN_IDX_W) ? CNTW : IN_IDX_W;
    localparam int PRODW = 2 * DOSE_W;

    // configuration
    logic [1:0]        r_metric;
    logic              r_simul;
    logic              r_use_struct;
    logic [DOSE_W-1:0] r_presc;

    // set statistics
    t_state            r_state, n_state;
    logic              r_closed;
    logic [CNTW-1:0]   r_total;
    logic [CNTW-1:0]   r_sel;
    logic [CNTW-1:0]   r_tenth;
    logic [3:0]        r_mod10;
    logic [SUMW-1:0]   r_sum;
    logic [DOSE_W-1:0] r_max;
    logic [DOSE_W-1:0] r_scale;
    logic [STATUS_W-1:0] r_status;
    logic [DOSE_W-1:0] r_ref;
    logic [CNTW-1:0]   r_rank;

    // read path
    logic [DOSE_W-1:0] r_rdata;
    logic [PRODW-1:0]  r_prod;
    logic              r_oob;
    logic [DOSE_W-1:0] mem [MAX_SAMPLES];

    logic              accept, ld, rd, take, pick;
    logic [CNTW-1:0]   base_total, base_sel, base_tenth;
    logic [3:0]        base_mod10;
    logic [SUMW-1:0]   base_sum;
    logic [DOSE_W-1:0] base_max;
    t_chain_ctl        chain_ctl;
    logic [DOSE_W-1:0] chain_head;

    logic              div_start, div_done;
    logic [DIVW-1:0]   div_dividend;
    logic [DOSE_W-1:0] div_divisor;
    logic [DIVW-1:0]   div_quo;
    logic [DOSE_W-1:0] scale_sat;
    logic [PRODW-1:0]  prod_sh;
    logic [DOSE_W-1:0] prod_sat;

    assign accept = start && !busy;
    assign ld     = accept && (i_op == OP_LOAD);
    assign rd     = accept && (i_op == OP_READ);

    // a load after a closed set starts from cleared statistics
    assign base_total = r_closed ? '0 : r_total;
    assign base_sel   = r_closed ? '0 : r_sel;
    assign base_tenth = r_closed ? '0 : r_tenth;
    assign base_mod10 = r_closed ? '0 : r_mod10;
    assign base_sum   = r_closed ? '0 : r_sum;
    assign base_max   = r_closed ? '0 : r_max;

    // drop samples beyond the store depth
    assign take = ld && (base_total < CNTW'(MAX_SAMPLES));
    assign pick = take && (!r_use_struct || i_in_structure);

    always_comb begin
        chain_ctl.clr   = ld && r_closed;
        chain_ctl.ins   = pick;
        chain_ctl.shift = (r_state == ST_SHIFT) && (r_rank != '0);
        chain_ctl.v     = i_dose_value;
    end

    drn_sort_chain #(
        .N (MAX_SAMPLES)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (chain_ctl),
        .o_head  (chain_head)
    );

    // one divider serves the mean and the scale quotient
    assign div_dividend = (r_state == ST_FIN) ? DIVW'(r_sum)
                                              : DIVW'({r_presc, {FRAC_BITS{1'b0}}});
    assign div_divisor  = (r_state == ST_FIN) ? DOSE_W'(r_sel) : r_ref;

    drn_divider #(
        .DIVW (DIVW),
        .DSW  (DOSE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign scale_sat = (|div_quo[DIVW-1:DOSE_W]) ? '1 : div_quo[DOSE_W-1:0];
    assign prod_sh   = r_prod >> FRAC_BITS;
    assign prod_sat  = (|prod_sh[PRODW-1:DOSE_W]) ? '1 : prod_sh[DOSE_W-1:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric     <= METRIC_MAX;
            r_simul      <= 1'b1;
            r_use_struct <= 1'b0;
            r_presc      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_METRIC: r_metric     <= i_cfg_data[1:0];
                CFG_SIMUL:  r_simul      <= i_cfg_data[0];
                CFG_STRUCT: r_use_struct <= i_cfg_data[0];
                CFG_PRESC:  r_presc      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (ld && i_last_sample) begin
                    n_state = ST_FIN;
                end else if (rd) begin
                    n_state = ST_RD_MUL;
                end
            end
            ST_FIN: begin
                if (!r_simul || (r_sel == '0)) begin
                    n_state = ST_REPORT;
                end else begin
                    case (r_metric)
                        METRIC_MEAN: n_state = ST_DIV_MEAN;
                        METRIC_D90:  n_state = ST_SHIFT;
                        default:     n_state = ST_REF;
                    endcase
                end
            end
            ST_SHIFT: begin
                if (r_rank == '0) begin
                    n_state = ST_REF;
                end
            end
            ST_DIV_MEAN: begin
                if (div_done) begin
                    n_state = ST_REF;
                end
            end
            ST_REF: begin
                n_state = (r_ref == '0) ? ST_REPORT : ST_DIV_SCALE;
            end
            ST_DIV_SCALE: begin
                if (div_done) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: n_state = ST_IDLE;
            ST_RD_MUL: n_state = ST_RD_OUT;
            ST_RD_OUT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy      = 1'b1;
        div_start = 1'b0;
        o_strobe  = 1'b0;
        o_kind    = KIND_REPORT;
        o_value   = '0;
        o_status  = STAT_OK;
        unique case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_FIN: begin
                div_start = r_simul && (r_sel != '0) && (r_metric == METRIC_MEAN);
            end
            ST_REF: div_start = (r_ref != '0);
            ST_REPORT: begin
                o_strobe = 1'b1;
                o_value  = r_scale;
                o_status = r_status;
            end
            ST_RD_OUT: begin
                o_strobe = 1'b1;
                o_kind   = KIND_DOSE;
                if (r_oob) begin
                    o_value = '0;
                end else if (!r_simul) begin
                    o_value = r_presc;
                end else begin
                    o_value  = prod_sat;
                    o_status = r_status;
                end
            end
            default: ;
        endcase
    end

    // control and set statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_closed <= 1'b0;
            r_total  <= '0;
            r_sel    <= '0;
            r_tenth  <= '0;
            r_mod10  <= '0;
            r_sum    <= '0;
            r_max    <= '0;
            r_scale  <= '0;
            r_status <= STAT_OK;
            r_ref    <= '0;
            r_rank   <= '0;
        end else begin
            r_state <= n_state;
            if (ld) begin
                r_closed <= i_last_sample;
                r_total  <= base_total + CNTW'(take);
                r_sel    <= base_sel + CNTW'(pick);
                r_sum    <= base_sum + (pick ? SUMW'(i_dose_value) : '0);
                r_max    <= (pick && (i_dose_value > base_max)) ? i_dose_value : base_max;
                // keep floor(count/10) alongside the count
                if (pick && (base_mod10 == TENTH_WRAP)) begin
                    r_mod10 <= '0;
                    r_tenth <= base_tenth + 1'b1;
                end else begin
                    r_mod10 <= base_mod10 + 4'(pick);
                    r_tenth <= base_tenth;
                end
            end
            case (r_state)
                ST_FIN: begin
                    r_ref  <= r_max;
                    r_rank <= r_tenth;
                    if (!r_simul) begin
                        r_scale  <= DOSE_W'(1) << FRAC_BITS;
                        r_status <= STAT_OK;
                    end else if (r_sel == '0) begin
                        r_scale  <= '0;
                        r_status <= STAT_EMPTY;
                    end
                end
                ST_SHIFT: begin
                    // advance the chain until the rank sits at its head
                    if (r_rank != '0) begin
                        r_rank <= r_rank - 1'b1;
                    end else begin
                        r_ref <= chain_head;
                    end
                end
                ST_DIV_MEAN: begin
                    if (div_done) begin
                        r_ref <= div_quo[DOSE_W-1:0];
                    end
                end
                ST_REF: begin
                    if (r_ref == '0) begin
                        r_scale  <= '0;
                        r_status <= STAT_ZERO_REF;
                    end
                end
                ST_DIV_SCALE: begin
                    if (div_done) begin
                        r_scale  <= scale_sat;
                        r_status <= STAT_OK;
                    end
                end
                default: ;
            endcase
        end
    end

    // sample store and read datapath
    always_ff @(posedge i_clk) begin
        if (take) begin
            mem[base_total[IDXW-1:0]] <= i_dose_value;
        end
        if (rd) begin
            r_rdata <= mem[IDXW'(i_read_index)];
            r_oob   <= CMPW'(i_read_index) >= CMPW'(r_total);
        end
        if (r_state == ST_RD_MUL) begin
            r_prod <= PRODW'(r_rdata) * PRODW'(r_scale);
        end
    end

    `DRN_ASSERT_NOW(a_strobe_busy, o_strobe, busy, "result strobe while idle")
    `DRN_ASSERT_NEXT(a_read_holds, rd, busy && (r_state == ST_RD_MUL), "read beat not held")
    `DRN_ASSERT_NOW(a_bad_ref_zero, o_strobe && (o_kind == KIND_REPORT) && (o_status != STAT_OK), o_value == '0, "nonzero scale with error status")
    `DRN_ASSERT_NOW(a_sel_le_total, 1'b1, (r_sel <= r_total) && (r_total <= CNTW'(MAX_SAMPLES)), "sample counts out of order")

endmodule

// ===== rtl/drn_cell.sv =====
`timescale 1ns / 1ps

module drn_cell import drn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_chain_ctl        i_ctl,
    input  logic [DOSE_W-1:0] i_prev_val,
    input  logic              i_prev_valid,
    input  logic              i_prev_gt,
    input  logic [DOSE_W-1:0] i_next_val,
    input  logic              i_next_valid,
    output logic [DOSE_W-1:0] o_val,
    output logic              o_valid,
    output logic              o_gt
);

    logic [DOSE_W-1:0] r_val;
    logic              r_valid;

    // effective occupancy: a pending clear empties the cell this cycle
    assign o_valid = r_valid && !i_ctl.clr;
    assign o_gt    = !o_valid || (r_val > i_ctl.v);
    assign o_val   = r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
        end else if (i_ctl.ins) begin
            r_valid <= o_valid || i_prev_valid;
        end else if (i_ctl.clr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_val <= i_next_val;
        end else if (i_ctl.ins && o_gt) begin
            r_val <= i_prev_gt ? i_prev_val : i_ctl.v;
        end
    end

endmodule

// ===== rtl/drn_sort_chain.sv =====
`timescale 1ns / 1ps

module drn_sort_chain import drn_pkg::*; #(
    parameter int N = MAX_SAMPLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_chain_ctl        i_ctl,
    output logic [DOSE_W-1:0] o_head
);

    logic [DOSE_W-1:0] c_val   [N];
    logic              c_valid [N];
    logic              c_gt    [N];

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic [DOSE_W-1:0] prev_val;
        logic              prev_valid;
        logic              prev_gt;
        logic [DOSE_W-1:0] next_val;
        logic              next_valid;

        if (i == 0) begin : g_first
            // left edge: a value always lands here once it beats every cell
            assign prev_val   = '0;
            assign prev_valid = 1'b1;
            assign prev_gt    = 1'b0;
        end else begin : g_mid
            assign prev_val   = c_val[i-1];
            assign prev_valid = c_valid[i-1];
            assign prev_gt    = c_gt[i-1];
        end

        if (i == N - 1) begin : g_last
            assign next_val   = '0;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_val   = c_val[i+1];
            assign next_valid = c_valid[i+1];
        end

        drn_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_prev_val   (prev_val),
            .i_prev_valid (prev_valid),
            .i_prev_gt    (prev_gt),
            .i_next_val   (next_val),
            .i_next_valid (next_valid),
            .o_val        (c_val[i]),
            .o_valid      (c_valid[i]),
            .o_gt         (c_gt[i])
        );
    end

    assign o_head = c_val[0];

endmodule

// ===== rtl/drn_divider.sv =====
`timescale 1ns / 1ps

module drn_divider import drn_pkg::*; #(
    parameter int DIVW = 48,
    parameter int DSW  = DOSE_W
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DIVW-1:0] i_dividend,
    input  logic [DSW-1:0]  i_divisor,
    output logic            o_done,
    output logic [DIVW-1:0] o_quotient
);

    localparam int CW = $clog2(DIVW + 1);

    logic            r_run;
    logic [CW-1:0]   r_cnt;
    logic [DIVW-1:0] r_quo;
    logic [DSW-1:0]  r_rem;
    logic [DSW-1:0]  r_div;

    logic [DSW:0] rem_sh;
    logic [DSW:0] diff;
    logic         ge;

    // restoring division, one quotient bit a cycle
    assign rem_sh = {r_rem, r_quo[DIVW-1]};
    assign ge     = rem_sh >= {1'b0, r_div};
    assign diff   = rem_sh - {1'b0, r_div};
    assign o_done = r_run && (r_cnt == '0);
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= CW'(DIVW);
        end else if (r_run) begin
            if (r_cnt == '0) begin
                r_run <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run && (r_cnt != '0)) begin
            r_rem <= ge ? diff[DSW-1:0] : rem_sh[DSW-1:0];
            r_quo <= {r_quo[DIVW-2:0], ge};
        end
    end

endmodule

// ===== tb/tb_dose_reference_normalizer.sv =====
`timescale 1ns / 1ps

module tb_dose_reference_normalizer;
    import drn_pkg::*;

    localparam int MAX_SAMPLES  = MAX_SAMPLES_DEF;
    localparam int FRAC_BITS    = FRAC_BITS_DEF;
    localparam int QUIET_LIMIT  = 5000;
    localparam int RANDOM_BEATS = 200;

    typedef struct {
        logic                kind;
        logic [DOSE_W-1:0]   value;
        logic [STATUS_W-1:0] status;
    } t_result;

    // DUT ports; every input is known from time zero
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic                 busy;
    logic                 i_op           = OP_LOAD;
    logic [DOSE_W-1:0]    i_dose_value   = '0;
    logic                 i_in_structure = 1'b0;
    logic                 i_last_sample  = 1'b0;
    logic [IN_IDX_W-1:0]  i_read_index   = '0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx      = CFG_METRIC;
    logic [DOSE_W-1:0]    i_cfg_data     = '0;
    logic                 o_strobe;
    logic                 o_kind;
    logic [DOSE_W-1:0]    o_value;
    logic [STATUS_W-1:0]  o_status;

    dose_reference_normalizer #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (.*);

    always #6 i_clk = ~i_clk;

    // Predictor state: mirrors the block's sample memory, set statistics and config
    logic [DOSE_W-1:0]   dose_mem [MAX_SAMPLES];
    logic [DOSE_W-1:0]   picked_doses[$];      // selected samples of the open set
    logic [DOSE_W-1:0]   peak_dose;
    logic [63:0]         dose_sum;
    int                  set_len;
    logic [DOSE_W-1:0]   scale;
    logic [STATUS_W-1:0] ref_stat;
    logic                set_done;
    logic [1:0]          cfg_metric;
    logic                cfg_simul;
    logic                cfg_struct;
    logic [DOSE_W-1:0]   cfg_presc;

    t_result pending_results[$];   // expected results, oldest first

    int  n_errors  = 0;
    int  n_loads   = 0;
    int  n_reads   = 0;
    int  n_reports = 0;
    int  n_status[3] = '{0, 0, 0};
    int  quiet     = 0;
    bit  calm      = 1'b0;         // no sender gaps while set

    // Work out the reference and scale for the set just closed
    task automatic close_set();
        logic [63:0] ref_dose;
        logic [63:0] quot;
        logic [DOSE_W-1:0] ranked[$];
        if (!cfg_simul) begin
            scale    = 32'h1 << FRAC_BITS;
            ref_stat = STAT_OK;
            return;
        end
        if (picked_doses.size() == 0) begin
            scale    = '0;
            ref_stat = STAT_EMPTY;
            return;
        end
        if (cfg_metric == METRIC_MEAN) begin
            ref_dose = dose_sum / picked_doses.size();
        end else if (cfg_metric == METRIC_D90) begin
            ranked = picked_doses;
            ranked.sort();
            ref_dose = ranked[picked_doses.size() / 10];
        end else begin
            ref_dose = peak_dose;   // metric three falls back to maximum
        end
        if (ref_dose == 0) begin
            scale    = '0;
            ref_stat = STAT_ZERO_REF;
            return;
        end
        quot     = ({32'h0, cfg_presc} << FRAC_BITS) / ref_dose;
        scale    = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
        ref_stat = STAT_OK;
    endtask

    // Advance the predictor by one accepted beat
    task automatic predict_beat(input logic op, input logic [DOSE_W-1:0] dose,
                                input logic memb, input logic last,
                                input logic [IN_IDX_W-1:0] idx);
        t_result     r;
        logic [63:0] prod;
        if (op == OP_LOAD) begin
            n_loads++;
            if (set_done) begin
                peak_dose = '0;
                dose_sum  = '0;
                set_len   = 0;
                picked_doses.delete();
                set_done  = 1'b0;
            end
            if (set_len < MAX_SAMPLES) begin
                dose_mem[set_len] = dose;
                set_len++;
                if (!cfg_struct || memb) begin
                    if (dose > peak_dose) peak_dose = dose;
                    dose_sum += dose;
                    picked_doses.insert(picked_doses.size(), dose);
                end
            end
            if (!last) return;
            close_set();
            set_done = 1'b1;
            r.kind   = KIND_REPORT;
            r.value  = scale;
            r.status = ref_stat;
            pending_results.insert(pending_results.size(), r);
            n_reports++;
            n_status[ref_stat]++;
            return;
        end
        n_reads++;
        r.kind = KIND_DOSE;
        if (idx >= set_len) begin
            r.value  = '0;
            r.status = STAT_OK;
        end else if (!cfg_simul) begin
            r.value  = cfg_presc;
            r.status = STAT_OK;
        end else begin
            prod     = ({32'h0, dose_mem[idx]} * {32'h0, scale}) >> FRAC_BITS;
            r.value  = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
            r.status = ref_stat;
        end
        pending_results.insert(pending_results.size(), r);
    endtask

    // Send one beat after a random gap; start stays high until the next gap
    task automatic send_beat(input logic op, input logic [DOSE_W-1:0] dose,
                             input logic memb, input logic last,
                             input logic [IN_IDX_W-1:0] idx);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_op           <= op;
        i_dose_value   <= dose;
        i_in_structure <= memb;
        i_last_sample  <= last;
        i_read_index   <= idx;
        do @(posedge i_clk); while (busy);
        predict_beat(op, dose, memb, last, idx);
    endtask

    task automatic load(input logic [DOSE_W-1:0] dose, input logic memb,
                        input logic last);
        send_beat(OP_LOAD, dose, memb, last, IN_IDX_W'($urandom));
    endtask

    task automatic read(input logic [IN_IDX_W-1:0] idx);
        send_beat(OP_READ, DOSE_W'($urandom), 1'($urandom), 1'($urandom), idx);
    endtask

    // Hold off until every expected beat has come back and the block is idle
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all four registers back to back while idle
    task automatic set_config(input logic [1:0] metric, input logic simul,
                              input logic strct, input logic [DOSE_W-1:0] presc);
        logic [DOSE_W-1:0] vals[4];
        logic [CFG_IDX_W-1:0] regs[4];
        drain();
        regs = '{CFG_METRIC, CFG_SIMUL, CFG_STRUCT, CFG_PRESC};
        vals = '{{30'h0, metric}, {31'h0, simul}, {31'h0, strct}, presc};
        foreach (regs[k]) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b0;
        cfg_metric = metric;
        cfg_simul  = simul;
        cfg_struct = strct;
        cfg_presc  = presc;
    endtask

    function automatic logic [DOSE_W-1:0] pick_dose();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return $urandom_range(0, 32'h3_FFFF);
            2:       return 32'h1_0000 * $urandom_range(1, 200);
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DOSE_W-1:0] pick_prescribed();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1_0000 * $urandom_range(1, 100);
            default: return $urandom;
        endcase
    endfunction

    // Edge cases: reset scale, extremes, every metric, empty set, zero reference
    task automatic test_directed();
        read(0);                                   // before any finalize
        set_config(METRIC_MAX, 1'b1, 1'b0, 32'h1_0000);
        load(32'h2_0000, 1'b0, 1'b0);
        load(32'hFFFF_FFFF, 1'b1, 1'b1);
        read(0);
        read(1);
        read(2);                                   // past the set
        read(10'h3FF);
        set_config(METRIC_MAX, 1'b1, 1'b0, 32'hFFFF_FFFF);
        load(32'h1, 1'b1, 1'b1);                   // scale saturates
        read(0);
        set_config(METRIC_MEAN, 1'b1, 1'b1, 32'h64_0000);
        load(32'h5, 1'b1, 1'b0);
        load(32'h0, 1'b0, 1'b0);
        load(32'h0, 1'b1, 1'b1);
        load(32'h1, 1'b1, 1'b0);                   // truncated mean is zero
        load(32'h0, 1'b1, 1'b1);
        read(0);
        load(32'h7, 1'b0, 1'b1);                   // nothing selected
        read(0);
        set_config(METRIC_D90, 1'b1, 1'b0, 32'h1_0000);
        load(32'h30_0000, 1'b0, 1'b0);
        load(32'h10_0000, 1'b1, 1'b0);
        load(32'h20_0000, 1'b0, 1'b1);
        set_config(2'd3, 1'b1, 1'b0, 32'h8_0000);
        load(32'h5_0000, 1'b1, 1'b1);
        set_config(METRIC_MAX, 1'b0, 1'b1, 32'h1234_5678);
        load(32'h9, 1'b0, 1'b1);
        read(0);
        read(5);
    endtask

    // Overflow: samples beyond the store are dropped, the last one still closes
    task automatic test_overflow();
        set_config(METRIC_MAX, 1'b1, 1'b0, 32'h1_0000);
        calm = 1'b1;
        for (int k = 0; k < MAX_SAMPLES + 6; k++)
            load(k == MAX_SAMPLES + 5 ? 32'hFFFF_FFFF : pick_dose() >> 1,
                 1'($urandom), k == MAX_SAMPLES + 5);
        calm = 1'b0;
        read(0);
        read(10'h3FF);
        read(IN_IDX_W'($urandom));
    endtask

    // Random sets under random configurations, with reads in and past each set
    task automatic test_random();
        int beats;
        int len;
        int phase;
        beats = 0;
        phase = 0;
        while (beats < RANDOM_BEATS) begin
            set_config(2'($urandom_range(0, 3)), $urandom_range(0, 4) != 0,
                       1'($urandom), pick_prescribed());
            calm = (phase % 5 == 4);
            for (int s = 0; s < 3; s++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 100)
                                                  : $urandom_range(1, 40);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        read(IN_IDX_W'($urandom_range(0, set_len)));   // read mid-set
                        beats++;
                    end
                    load(pick_dose(), 1'($urandom), k == len - 1);
                    beats++;
                end
                repeat ($urandom_range(1, 8)) begin
                    read(IN_IDX_W'($urandom_range(0, 4) == 0 ? $urandom
                                                             : $urandom_range(0, len)));
                    beats++;
                end
                if ($urandom_range(0, 3) == 0) drain();     // sender waits for all
            end
            phase++;
        end
        calm = 1'b0;
    endtask

    // Check each result beat against the oldest expectation; watch for stalls
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: kind %0d value %h status %0d",
                       o_kind, o_value, o_status);
                n_errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_kind !== exp_r.kind) begin
                    $error("kind: expected %0d, actual %0d", exp_r.kind, o_kind);
                    n_errors++;
                end
                if (o_value !== exp_r.value) begin
                    $error("value: expected %h, actual %h", exp_r.value, o_value);
                    n_errors++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, o_status);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        peak_dose  = '0;
        dose_sum   = '0;
        set_len    = 0;
        scale      = '0;
        ref_stat   = STAT_OK;
        set_done   = 1'b0;
        cfg_metric = METRIC_MAX;
        cfg_simul  = 1'b1;
        cfg_struct = 1'b0;
        cfg_presc  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_overflow();
        test_random();

        drain();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d loads, %0d reads, %0d finalize reports", n_loads, n_reads,
                 n_reports);
        $display("Report status ok/zero-ref/empty: %0d/%0d/%0d", n_status[0],
                 n_status[1], n_status[2]);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
